/* src/gbts_pkg.sv */
// ----------------------------------------------------------------------------
// gbts_pkg
// shared constants, codes and types of the gap-buffer text store
// ----------------------------------------------------------------------------
package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = POS_W + 1;

    localparam logic [POS_W-1:0] CAP_LEN = POS_W'(CAPACITY);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOTHING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_MOVE_RD   = 6'b000010,
        S_MOVE_WR   = 6'b000100,
        S_EXEC      = 6'b001000,
        S_READ_WAIT = 6'b010000,
        S_FINISH    = 6'b100000
    } state_t;

endpackage

/* src/gap_buffer_text_store_top.sv */
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top
// gap-buffer text store: byte read, byte insert and run delete on one memory
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A read goes through S_READ_WAIT to
// the result register; an insert or delete shifts bytes across the gap in
// S_MOVE_RD and S_MOVE_WR, the gap moving one byte per read and write-back
// of the single text memory, then executes in S_EXEC. Requests that do
// nothing go straight to S_FINISH. The next transaction can be taken in the
// cycle after the result register is loaded. A result waits in the output
// register while the next transaction is taken in.
module gap_buffer_text_store_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position[12:0], data_byte[20:13], count[33:21], zero padding
    input  logic [gbts_pkg::IN_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_byte[7:0], read_valid[8], text_length[21:9], status[23:22]
    output logic [gbts_pkg::OUT_DATA_W-1:0] m_tdata
);
    import gbts_pkg::*;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  gap_start_reg, gap_start_next;
    logic [POS_W-1:0]  gap_size_reg, gap_size_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        byte_reg, byte_next;
    logic              is_insert_reg, is_insert_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_valid_reg, res_valid_next;
    status_t           res_status_reg, res_status_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [7:0]        mem [CAPACITY];
    logic [7:0]        rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [7:0]        mem_wd;

    logic [POS_W-1:0]  in_pos, in_cnt, len, remain, read_idx;
    logic [7:0]        in_byte;
    logic              accept;

    assign in_pos   = s_tdata[12:0];
    assign in_byte  = s_tdata[20:13];
    assign in_cnt   = s_tdata[33:21];
    assign len      = CAP_LEN - gap_size_reg;
    assign remain   = len - in_pos;
    assign read_idx = (in_pos < gap_start_reg) ? in_pos : in_pos + gap_size_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        gap_start_next  = gap_start_reg;
        gap_size_next   = gap_size_reg;
        target_next     = target_reg;
        cnt_next        = cnt_reg;
        byte_next       = byte_reg;
        is_insert_next  = is_insert_reg;
        res_byte_next   = res_byte_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wa          = gap_start_reg[ADDR_W-1:0];
        mem_ra          = read_idx[ADDR_W-1:0];
        mem_wd          = byte_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_byte_next   = 8'd0;
                    res_valid_next  = 1'b0;
                    res_status_next = ST_NOTHING;
                    byte_next       = in_byte;
                    state_next      = S_FINISH;
                    case (req_t'(s_tuser))
                        REQ_READ: begin
                            if (in_pos < len) begin
                                mem_re     = 1'b1;
                                state_next = S_READ_WAIT;
                            end
                        end
                        REQ_INSERT: begin
                            if (gap_size_reg == '0) begin
                                res_status_next = ST_FULL;
                            end else begin
                                target_next    = (in_pos > len) ? len : in_pos;
                                is_insert_next = 1'b1;
                                state_next     = S_MOVE_RD;
                            end
                        end
                        REQ_DELETE: begin
                            if (in_pos < len && in_cnt != '0) begin
                                target_next    = in_pos;
                                cnt_next       = (in_cnt > remain) ? remain : in_cnt;
                                is_insert_next = 1'b0;
                                state_next     = S_MOVE_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOVE_RD: begin
                if (target_reg == gap_start_reg) begin
                    state_next = S_EXEC;
                end else begin
                    mem_re = 1'b1;
                    if (target_reg < gap_start_reg) begin
                        mem_ra = ADDR_W'(gap_start_reg - POS_W'(1));
                    end else begin
                        mem_ra = ADDR_W'(gap_start_reg + gap_size_reg);
                    end
                    state_next = S_MOVE_WR;
                end
            end
            S_MOVE_WR: begin
                mem_we = 1'b1;
                mem_wd = rd_data_reg;
                if (target_reg < gap_start_reg) begin
                    mem_wa         = ADDR_W'(gap_start_reg - POS_W'(1) + gap_size_reg);
                    gap_start_next = gap_start_reg - POS_W'(1);
                end else begin
                    mem_wa         = gap_start_reg[ADDR_W-1:0];
                    gap_start_next = gap_start_reg + POS_W'(1);
                end
                state_next = S_MOVE_RD;
            end
            S_EXEC: begin
                if (is_insert_reg) begin
                    mem_we         = 1'b1;
                    gap_start_next = gap_start_reg + POS_W'(1);
                    gap_size_next  = gap_size_reg - POS_W'(1);
                end else begin
                    gap_size_next = gap_size_reg + cnt_reg;
                end
                res_status_next = ST_DONE;
                state_next      = S_FINISH;
            end
            S_READ_WAIT: begin
                res_byte_next   = rd_data_reg;
                res_valid_next  = 1'b1;
                res_status_next = ST_DONE;
                state_next      = S_FINISH;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_status_reg, len, res_valid_reg, res_byte_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            gap_start_reg <= '0;
            gap_size_reg  <= CAP_LEN;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gap_start_reg <= gap_start_next;
            gap_size_reg  <= gap_size_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg     <= target_next;
        cnt_reg        <= cnt_next;
        byte_reg       <= byte_next;
        is_insert_reg  <= is_insert_next;
        res_byte_reg   <= res_byte_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // text memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // gap never runs past the end of the store
    a_gap_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, gap_start_reg} + {1'b0, gap_size_reg}) <= SUM_W'(CAPACITY))
        else $error("gap beyond store end");

    // gap moves only towards a target inside the text
    a_target_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE_RD || state_reg == S_MOVE_WR) |-> target_reg <= len)
        else $error("gap target outside text");

    // an insert executes only with room left
    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && is_insert_reg) |-> gap_size_reg != '0)
        else $error("insert into full store");

    // a shift step always follows its read
    a_shift_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE_WR) |-> $past(state_reg) == S_MOVE_RD)
        else $error("shift write without read");

endmodule

/* tb/sv/gap_buffer_text_store_top_tb.sv */
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top_tb
// self-checking bench for the gap-buffer text store: reads, inserts and run
// deletes are driven over the input stream and every result transaction is
// compared field by field with a byte-queue model of the stored text
// ----------------------------------------------------------------------------
module gap_buffer_text_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbts_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         POS_MAX    = 8191;
    localparam int         REPORT_MAX = 10;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] text_length;
        logic             read_valid;
        logic [7:0]       read_byte;
    } store_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [7:0]    text_bytes[$];
    store_result_t pending_results[$];
    int            fail_count = 0;
    int            stall_left = 0;
    bit            idling_on  = 1'b1;

    gap_buffer_text_store_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1ns aclk = ~aclk;

    function automatic store_result_t model_request(logic [1:0] req, int pos,
                                                    logic [7:0] data, int cnt);
        store_result_t r;
        int            len;
        int            n;
        r        = '0;
        r.status = ST_NOTHING;
        len      = text_bytes.size();
        case (req)
            REQ_READ: begin
                if (pos < len) begin
                    r.read_byte  = text_bytes[pos];
                    r.read_valid = 1'b1;
                    r.status     = ST_DONE;
                end
            end
            REQ_INSERT: begin
                if (len == CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    text_bytes.insert((pos > len) ? len : pos, data);
                    r.status = ST_DONE;
                end
            end
            REQ_DELETE: begin
                if (pos < len && cnt != 0) begin
                    n = (cnt > len - pos) ? len - pos : cnt;
                    repeat (n) text_bytes.delete(pos);
                    r.status = ST_DONE;
                end
            end
            default: ;
        endcase
        r.text_length = POS_W'(text_bytes.size());
        return r;
    endfunction

    task automatic hold_input(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic issue_request(logic [1:0] req, int pos, logic [7:0] data, int cnt);
        if (idling_on && $urandom_range(0, 3) == 0)
            hold_input($urandom_range(1, 10));
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, cnt[12:0], data, pos[12:0]};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(model_request(req, pos & POS_MAX, data, cnt & POS_MAX));
    endtask

    // receiver stalls in random bursts while idling is enabled
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        store_result_t got;
        store_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = store_result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result transaction: %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
                    got.text_length !== want.text_length || got.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"result mismatch: expected byte %h valid %b length %0d ",
                                  "status %0d, got byte %h valid %b length %0d status %0d"},
                                 want.read_byte, want.read_valid, want.text_length,
                                 want.status, got.read_byte, got.read_valid,
                                 got.text_length, got.status);
                end
            end
        end
    end

    task automatic test_directed_cases();
        // empty text: reads and deletes do nothing
        issue_request(REQ_READ, 0, 8'h00, 0);
        issue_request(REQ_READ, POS_MAX, 8'hff, POS_MAX);
        issue_request(REQ_DELETE, 0, 8'h00, 1);
        // inserts, two clamped to the end of the text
        issue_request(REQ_INSERT, POS_MAX, 8'h00, 0);
        issue_request(REQ_INSERT, 0, 8'hff, POS_MAX);
        issue_request(REQ_INSERT, 1, 8'h5a, 0);
        issue_request(REQ_INSERT, 3, 8'ha5, 0);
        issue_request(REQ_INSERT, CAPACITY, 8'h3c, 0);
        issue_request(REQ_INSERT, 2, 8'h81, 0);
        for (int p = 0; p <= 6; p++)
            issue_request(REQ_READ, p, 8'($urandom), POS_MAX);
        issue_request(REQ_UNUSED, POS_MAX, 8'hff, POS_MAX);
        issue_request(REQ_UNUSED, 0, 8'h00, 0);
        // deletes: zero count, at end, past end, inside, trimmed
        issue_request(REQ_DELETE, 1, 8'hff, 0);
        issue_request(REQ_DELETE, 6, 8'h00, 1);
        issue_request(REQ_DELETE, POS_MAX, 8'h00, POS_MAX);
        issue_request(REQ_DELETE, 1, 8'h00, 2);
        issue_request(REQ_READ, 1, 8'h00, 0);
        issue_request(REQ_DELETE, 2, 8'h00, POS_MAX);
        issue_request(REQ_READ, 1, 8'h00, 0);
    endtask

    task automatic test_random_edits(int n_items, bit with_idling);
        int         len;
        int         pick;
        int         pos;
        int         cnt;
        logic [1:0] req;
        idling_on <= with_idling;
        for (int i = 0; i < n_items; i++) begin
            if (with_idling && i > 0 && i % 150 == 0)
                idling_on <= ($urandom_range(0, 3) != 0);
            if (with_idling && i == n_items / 2)
                drain_results();
            len  = text_bytes.size();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                req = REQ_UNUSED;
            else if (pick < 38)
                req = REQ_READ;
            else if (pick < ((len > 48) ? 60 : 80))
                req = REQ_INSERT;
            else
                req = REQ_DELETE;
            pos = ($urandom_range(0, 15) == 0) ? $urandom_range(0, POS_MAX)
                                               : $urandom_range(0, len + 1);
            cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, POS_MAX)
                                               : $urandom_range(0, 6);
            issue_request(req, pos, 8'($urandom), cnt);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_edits(750, 1'b1);
        test_random_edits(120, 1'b0);
        drain_results();
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (fail_count == 0)
            $display("gap_buffer_text_store_top_tb OK");
        else
            $display("gap_buffer_text_store_top_tb NOT OK");
        $finish;
    end

    initial begin
        #10_000_000ns;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("gap_buffer_text_store_top_tb NOT OK");
        $finish;
    end

endmodule
